FILE: rtl/prq_pkg.sv
// ---------------------------------------------------------------------------
// prq_pkg : shared types and constants of the priority ready queue
// Entry layout, request and response beats, status and request codes.
// ---------------------------------------------------------------------------
package prq_pkg;

    localparam int DEPTH     = 16;
    localparam int ID_BITS   = 8;
    localparam int PRIO_BITS = 8;
    localparam int OCC_BITS  = $clog2(DEPTH + 1);

    typedef enum logic {
        REQ_ENQ = 1'b0,
        REQ_DEQ = 1'b1
    } t_req_type;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // request beat
    typedef struct packed {
        t_req_type              req_type;
        logic [ID_BITS-1:0]     proc_id;
        logic [PRIO_BITS-1:0]   priority_req;
    } t_req;

    // response beat
    typedef struct packed {
        t_status                status;
        logic [ID_BITS-1:0]     out_id;
        logic [PRIO_BITS-1:0]   out_priority;
        logic [OCC_BITS-1:0]    occupancy;
    } t_rsp;

    // one stored entry
    typedef struct packed {
        logic                   valid;
        logic [ID_BITS-1:0]     id;
        logic [PRIO_BITS-1:0]   prio;
    } t_entry;

    // what a cell shows its neighbours
    typedef struct packed {
        t_entry                 ent;
        logic                   ins;   // new entry belongs at or before this cell
    } t_link;

    // broadcast command to every cell
    typedef struct packed {
        logic                   enq;
        logic                   deq;
        logic [ID_BITS-1:0]     id;
        logic [PRIO_BITS-1:0]   prio;
    } t_cmd;

endpackage

FILE: rtl/prq_cell.sv
// ---------------------------------------------------------------------------
// prq_cell : one slot of the sorted shift chain
// Holds one entry; on enqueue takes the new entry or its upper neighbour,
// on dequeue takes its lower neighbour.
// ---------------------------------------------------------------------------
module prq_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  prq_pkg::t_cmd   i_cmd,
    input  prq_pkg::t_link  i_prev,
    input  prq_pkg::t_entry i_next,
    output prq_pkg::t_link  o_link
);
    import prq_pkg::*;

    t_entry r_ent;
    t_entry n_ent;
    logic   w_ins;

    // strictly greater: equal priorities stay behind, first in first out
    assign w_ins  = !r_ent.valid || (i_cmd.prio > r_ent.prio);
    assign o_link = '{ent: r_ent, ins: w_ins};

    always_comb begin
        n_ent = r_ent;
        priority if (i_cmd.enq && w_ins) begin
            if (i_prev.ins) begin
                n_ent = i_prev.ent;
            end else begin
                n_ent = '{valid: 1'b1, id: i_cmd.id, prio: i_cmd.prio};
            end
        end else if (i_cmd.deq) begin
            n_ent = i_next;
        end
    end

    // only the valid bit is reset; payload follows unconditionally
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent.valid <= 1'b0;
        end else begin
            r_ent.valid <= n_ent.valid;
        end
        r_ent.id   <= n_ent.id;
        r_ent.prio <= n_ent.prio;
    end

endmodule

FILE: rtl/priority_ready_queue.sv
// ---------------------------------------------------------------------------
// priority_ready_queue : bounded sorted ready queue of processes
// Chain of shift cells kept in priority order, head in cell 0.
// ---------------------------------------------------------------------------
// Usage:
//   Request channel: drive i_req and raise i_start; the beat is taken at the
//   rising edge where i_start is high and o_busy is low. o_busy never rises,
//   so one request may be taken every cycle.
//   Response channel: o_done pulses for one cycle with o_rsp, in the cycle
//   after the request edge. There is no back-pressure; the receiver
//   must capture the beat in that cycle.
//   Throughput 1 item per cycle. Every cell compares the
//   incoming priority against its own entry in parallel and shifts in the
//   same edge, so the chain of DEPTH cells sets no iteration count.
//   Enqueue: the entry lands ahead of all strictly lower priorities; a full
//   queue drops it and reports ST_FULL. Dequeue: the head leaves and the
//   chain moves up one cell; an empty queue reports ST_EMPTY.
//   Reset (synchronous, active low) empties the queue at once: only the
//   valid bits and counters are cleared, stored payload is left as is.
// ---------------------------------------------------------------------------
module priority_ready_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  prq_pkg::t_req i_req,
    output logic          o_busy,
    output logic          o_done,
    output prq_pkg::t_rsp o_rsp
);
    import prq_pkg::*;

    t_link               w_link [DEPTH];
    t_cmd                w_cmd;
    logic                w_accept;
    logic                w_is_deq;
    logic                w_empty;
    logic                w_full;
    logic [DEPTH-1:0]    w_valid;

    logic [OCC_BITS-1:0] r_count;
    logic [OCC_BITS-1:0] n_count;
    logic                r_done;
    t_rsp                r_rsp;
    t_rsp                n_rsp;

    // every cell updates at the same edge, so never busy
    assign o_busy   = 1'b0;
    assign w_accept = i_start && !o_busy;
    assign w_is_deq = (i_req.req_type == REQ_DEQ);

    // valid cells form a block from the head, so the ends tell empty/full
    assign w_empty  = !w_link[0].ent.valid;
    assign w_full   = w_link[DEPTH-1].ent.valid;

    assign w_cmd.enq  = w_accept && !w_is_deq && !w_full;
    assign w_cmd.deq  = w_accept && w_is_deq && !w_empty;
    assign w_cmd.id   = i_req.proc_id;
    assign w_cmd.prio = i_req.priority_req;

    // cell chain
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        t_link  w_prev;
        t_entry w_next;

        if (gi == 0) begin : g_head
            assign w_prev = '0;            // nothing above the head
        end else begin : g_mid
            assign w_prev = w_link[gi-1];
        end

        if (gi == DEPTH - 1) begin : g_tail
            assign w_next = '0;            // empty slot shifts in at the tail
        end else begin : g_body
            assign w_next = w_link[gi+1].ent;
        end

        prq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_cmd),
            .i_prev  (w_prev),
            .i_next  (w_next),
            .o_link  (w_link[gi])
        );

        assign w_valid[gi] = w_link[gi].ent.valid;
    end

    // occupancy tracks the valid block length
    always_comb begin
        n_count = r_count;
        if (w_cmd.enq) begin
            n_count = r_count + OCC_BITS'(1);
        end else if (w_cmd.deq) begin
            n_count = r_count - OCC_BITS'(1);
        end
    end

    // response beat
    always_comb begin
        n_rsp           = '0;
        n_rsp.status    = ST_OK;
        n_rsp.occupancy = n_count;
        if (w_is_deq) begin
            if (w_empty) begin
                n_rsp.status = ST_EMPTY;
            end else begin
                n_rsp.out_id       = w_link[0].ent.id;
                n_rsp.out_priority = w_link[0].ent.prio;
            end
        end else if (w_full) begin
            n_rsp.status = ST_FULL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

`ifndef ASSERT_OFF
    // counter agrees with the cell chain
    a_count_match : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) == $countones(w_valid))
        else $error("occupancy counter out of step with valid cells");

    // valid cells are contiguous from the head
    a_valid_block : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid & (w_valid + DEPTH'(1))) == '0)
        else $error("hole in the valid block");

    // every accepted beat gives one response in the next cycle
    a_done_follow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_done)
        else $error("response beat missing");

    // empty report only with nothing held
    a_empty_occ : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.status == ST_EMPTY) |-> (o_rsp.occupancy == '0))
        else $error("empty status with entries held");

    // chain stays sorted, highest priority first
    for (genvar gk = 0; gk < DEPTH - 1; gk++) begin : g_sorted
        a_sorted : assert property (@(posedge i_clk) disable iff (!i_rst_n)
            w_link[gk+1].ent.valid |-> (w_link[gk].ent.prio >= w_link[gk+1].ent.prio))
            else $error("chain out of priority order");
    end
`endif

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top : self-checking bench for the priority ready queue
// Drives enqueue and dequeue beats in a directed run and in random bursts and predicts each
// response with a sorted-array queue of its own. Every response beat is
// compared field by field.
// ---------------------------------------------------------------------------
module tb_top;

    import prq_pkg::*;

    localparam int NUM_RANDOM = 950;
    localparam int IDLE_LIMIT = 1000;   // cycles with no beat in either direction

    // -----------------------------------------------------------------------
    // Scoreboard: keeps its own sorted copy of the queue, computes the
    // response each accepted request beat should give and checks the beats
    // that come back, oldest first.
    // -----------------------------------------------------------------------
    class ready_queue_scoreboard;
        logic [ID_BITS-1:0]   held_id   [DEPTH];
        logic [PRIO_BITS-1:0] held_prio [DEPTH];
        int unsigned          held_count;
        t_rsp                 expected_rsp [$];
        int                   errors;
        int                   n_checked, n_enq, n_deq, n_empty, n_full, peak;

        function new();
            held_count = 0;
            errors     = 0;
            n_checked  = 0;
            n_enq      = 0;
            n_deq      = 0;
            n_empty    = 0;
            n_full     = 0;
            peak       = 0;
        endfunction

        // accepted request beat: update the queue copy, queue the response
        function void note_request(t_req req);
            t_rsp        rsp;
            int unsigned pos;
            rsp        = '0;
            rsp.status = ST_OK;
            if (req.req_type == REQ_DEQ) begin
                n_deq++;
                if (held_count == 0) begin
                    rsp.status = ST_EMPTY;
                    n_empty++;
                end else begin
                    rsp.out_id       = held_id[0];
                    rsp.out_priority = held_prio[0];
                    for (int i = 0; i + 1 < held_count; i++) begin
                        held_id[i]   = held_id[i + 1];
                        held_prio[i] = held_prio[i + 1];
                    end
                    held_count--;
                end
            end else begin
                n_enq++;
                if (held_count >= DEPTH) begin
                    rsp.status = ST_FULL;
                    n_full++;
                end else begin
                    // behind every entry of equal or higher priority
                    pos = 0;
                    while (pos < held_count && held_prio[pos] >= req.priority_req)
                        pos++;
                    for (int i = held_count; i > pos; i--) begin
                        held_id[i]   = held_id[i - 1];
                        held_prio[i] = held_prio[i - 1];
                    end
                    held_id[pos]   = req.proc_id;
                    held_prio[pos] = req.priority_req;
                    held_count++;
                    if (held_count > peak)
                        peak = held_count;
                end
            end
            rsp.occupancy = held_count[OCC_BITS-1:0];
            expected_rsp.push_back(rsp);
        endfunction

        function void check_response(t_rsp got);
            t_rsp want;
            if (expected_rsp.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("[%0t] unexpected response beat: status=%0d id=%0d prio=%0d occ=%0d",
                             $time, got.status, got.out_id, got.out_priority, got.occupancy);
                return;
            end
            want = expected_rsp.pop_front();
            n_checked++;
            if (got.status !== want.status || got.out_id !== want.out_id ||
                got.out_priority !== want.out_priority || got.occupancy !== want.occupancy) begin
                errors++;
                if (errors <= 10)
                    $display("[%0t] mismatch: exp status=%0d id=%0d prio=%0d occ=%0d, got status=%0d id=%0d prio=%0d occ=%0d",
                             $time, want.status, want.out_id, want.out_priority, want.occupancy,
                             got.status, got.out_id, got.out_priority, got.occupancy);
            end
        endfunction

        function int pending();
            return expected_rsp.size();
        endfunction
    endclass

    // -----------------------------------------------------------------------
    // DUT and its signals
    // -----------------------------------------------------------------------
    logic i_clk;
    logic i_rst_n;
    logic i_start;
    t_req i_req;
    logic o_busy;
    logic o_done;
    t_rsp o_rsp;

    priority_ready_queue dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_req   (i_req),
        .o_busy  (o_busy),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    ready_queue_scoreboard sb = new();

    // 12 ns clock
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // -----------------------------------------------------------------------
    // Monitor: values seen here are those from before the edge, so the
    // drivers' nonblocking updates at the same edge cannot race it.
    // Response checked before the new request is noted; since the response is
    // registered, the two never refer to the same beat.
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done)
                sb.check_response(o_rsp);
            if (i_start && !o_busy)
                sb.note_request(i_req);
        end
    end

    // Watchdog: counts cycles in which no beat moves either way
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_done) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no beat for %0d cycles, %0d responses outstanding",
                         IDLE_LIMIT, sb.pending());
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Driver tasks. Each is entered and left just after a rising edge.
    // -----------------------------------------------------------------------

    // present one request beat and hold it until taken
    task automatic send_beat(input t_req req);
        i_req   <= req;
        i_start <= 1'b1;
        @(posedge i_clk);
        while (o_busy)
            @(posedge i_clk);
    endtask

    task automatic idle_for(input int cycles);
        i_start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // sender holds off until every outstanding response has arrived
    task automatic wait_drained();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    function automatic t_req make_req(input t_req_type kind, input int id, input int prio);
        t_req req;
        req.req_type     = kind;
        req.proc_id      = id[ID_BITS-1:0];
        req.priority_req = prio[PRIO_BITS-1:0];
        return req;
    endfunction

    // priorities weighted towards ties and the two extremes
    function automatic int pick_prio();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return (1 << PRIO_BITS) - 1;
            2, 3:    return $urandom_range(0, 3);
            4:       return $urandom_range(120, 123);
            default: return $urandom_range(0, (1 << PRIO_BITS) - 1);
        endcase
    endfunction

    // mode 0 leans to filling, 1 to draining, 2 is even
    function automatic t_req random_req(input int mode);
        int        deq_pct;
        t_req_type kind;
        deq_pct = (mode == 0) ? 20 : (mode == 1) ? 80 : 50;
        kind    = ($urandom_range(0, 99) < deq_pct) ? REQ_DEQ : REQ_ENQ;
        // unused fields on a dequeue still get random values
        return make_req(kind, $urandom_range(0, (1 << ID_BITS) - 1), pick_prio());
    endfunction

    // priorities for the directed fill: extremes, ties at the top, middle
    // and bottom, so first in, first out ordering within a level shows
    localparam logic [PRIO_BITS-1:0] FILL_PRIO [DEPTH] = '{
        8'd0,   8'd255, 8'd255, 8'd128, 8'd128, 8'd0,   8'd1,   8'd254,
        8'd128, 8'd255, 8'd0,   8'd127, 8'd129, 8'd128, 8'd1,   8'd255
    };

    // -----------------------------------------------------------------------
    // Stimulus
    // -----------------------------------------------------------------------
    initial begin
        int sent;
        int burst;
        int mode;
        int pauses;

        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_req   = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty dequeue, fill to the brim, overflow, partial drain
        send_beat(make_req(REQ_DEQ, 8'hFF, 8'hFF));
        for (int k = 0; k < DEPTH; k++)
            send_beat(make_req(REQ_ENQ, k * 17, FILL_PRIO[k]));
        send_beat(make_req(REQ_ENQ, 8'hAA, 8'hFF));   // dropped, queue full
        for (int k = 0; k < 4; k++)
            send_beat(make_req(REQ_DEQ, 0, 0));

        // sender pause with nothing in flight
        wait_drained();

        // random bursts with random gaps; back-to-back stretches too
        sent   = 0;
        pauses = 0;
        while (sent < NUM_RANDOM) begin
            mode  = $urandom_range(0, 2);
            burst = $urandom_range(1, 24);
            for (int b = 0; b < burst && sent < NUM_RANDOM; b++) begin
                send_beat(random_req(mode));
                sent++;
            end
            if (pauses == 0 && sent >= NUM_RANDOM / 2) begin
                wait_drained();
                pauses++;
            end else if ($urandom_range(0, 3) != 0) begin
                idle_for($urandom_range(1, 8));
            end
        end

        wait_drained();
        repeat (4) @(posedge i_clk);

        $display("Covered %0d enqueues (%0d refused when full) and %0d dequeues (%0d on empty),",
                 sb.n_enq, sb.n_full, sb.n_deq, sb.n_empty);
        $display("%0d responses checked, peak occupancy %0d of %0d, %0d mismatches",
                 sb.n_checked, sb.peak, DEPTH, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/prq_pkg.sv
rtl/prq_cell.sv
rtl/priority_ready_queue.sv
sim/tb_top.sv
